// ----- hdl/assert_macros.svh -----
// Assertion helpers for the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/clle_pkg.sv -----
package clle_pkg;

   localparam int ListSlots = 256;
   localparam int SlotW = $clog2(ListSlots);
   localparam int CountW = $clog2(ListSlots + 1);
   localparam int PosW = 9;
   localparam int ValW = 32;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_GET    = 3'd2,
      OP_SEARCH = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]      opcode;
      logic [PosW-1:0] position;
      logic [ValW-1:0] item_value;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_FREE_SCAN,
      BK_WALK_REQ,
      BK_WALK_WAIT,
      BK_VAL_WAIT,
      BK_SRCH_REQ,
      BK_SRCH_WAIT,
      BK_DEL_WAIT,
      BK_CLEAR,
      BK_DONE
   } back_state_type;

endpackage

// ----- hdl/cursor_linked_list_engine_top.sv -----
// Linked list engine over 256 slots. A request is taken when start is high
// and busy is low; exactly one result follows, shown for one cycle with
// rsp_strobe, and the receiver cannot stall it. Busy rises when the two-entry
// command queue is full. A walk follows one link per read of the slot memory
// (the read is issued, then its data is taken); a get or a search walks the
// list in this way from its head. Inserts first scan the used marks one slot
// per cycle for the lowest free slot. Commands queued behind a long one wait
// for it.
`include "assert_macros.svh"
module cursor_linked_list_engine_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_opcode,
   input  logic [8:0]          req_position,
   input  logic signed [31:0]  req_item_value,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_read_value,
   output logic [7:0]          rsp_slot_index,
   output logic [8:0]          rsp_element_count
);

   logic              q_pop, q_full, q_valid, back_idle;
   clle_pkg::cmd_type q_cmd;

   assign busy = q_full;

   clle_front u_front (
      .clock, .reset, .req_start(start), .req_opcode, .req_position, .req_item_value,
      .q_pop, .q_full, .q_valid, .q_cmd
   );

   clle_back u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .idle(back_idle),
      .rsp_strobe, .rsp_status, .rsp_read_value, .rsp_slot_index, .rsp_element_count
   );

   `ASSERT_IMPL(a_pop_idle, clock, reset, q_pop, back_idle && q_valid,
                "queue popped while back end busy")

endmodule

// ----- hdl/clle_front.sv -----
module clle_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   input  logic [2:0]           req_opcode,
   input  logic [8:0]           req_position,
   input  logic signed [31:0]   req_item_value,
   input  logic                 q_pop,
   output logic                 q_full,
   output logic                 q_valid,
   output clle_pkg::cmd_type    q_cmd
);

   clle_pkg::cmd_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       push;

   assign q_full  = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = slot_ff[rd_ptr_ff];
   assign push    = req_start && !q_full;

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{opcode: req_opcode, position: req_position,
                                 item_value: req_item_value};
      end
   end

endmodule

// ----- hdl/clle_back.sv -----
`include "assert_macros.svh"
module clle_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  clle_pkg::cmd_type           q_cmd,
   output logic                        q_pop,
   output logic                        idle,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_read_value,
   output logic [7:0]                  rsp_slot_index,
   output logic [8:0]                  rsp_element_count
);

   localparam int SW = clle_pkg::SlotW;
   localparam int CW = clle_pkg::CountW;

   logic [31:0]   elem_mem [clle_pkg::ListSlots];
   logic [SW-1:0] link_mem [clle_pkg::ListSlots];
   logic [clle_pkg::ListSlots-1:0] used_ff, used_in;

   clle_pkg::back_state_type state_ff, state_in;
   clle_pkg::cmd_type cmd_ff, cmd_in;
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] len_ff, len_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [CW-1:0] step_ff, step_in;
   logic [SW-1:0] free_ff, free_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   rd_ff, rd_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          strobe_ff, strobe_in;

   logic          rd_en;
   logic [SW-1:0] rd_addr;
   logic [31:0]   elem_q;
   logic [SW-1:0] link_q;
   logic          ew_en, lw_en;
   logic [SW-1:0] ew_addr, lw_addr, lw_data;
   logic [31:0]   ew_data;
   logic [CW-1:0] target;
   logic [CW-1:0] pos_ext;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         elem_q <= elem_mem[rd_addr];
         link_q <= link_mem[rd_addr];
      end
      if (ew_en) elem_mem[ew_addr] <= ew_data;
      if (lw_en) link_mem[lw_addr] <= lw_data;
   end

   assign pos_ext = CW'(cmd_ff.position);
   assign target  = (cmd_ff.opcode == clle_pkg::OP_GET) ? pos_ext : pos_ext - CW'(1);

   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;  head_in = head_ff;  len_in = len_ff;
      cur_in = cur_ff;  step_in = step_ff;  free_in = free_ff;  scan_in = scan_ff;
      st_in = st_ff;  rd_in = rd_ff;  slot_in = slot_ff;  used_in = used_ff;
      strobe_in = 1'b0;  q_pop = 1'b0;
      rd_en = 1'b0;  rd_addr = cur_ff;
      ew_en = 1'b0;  ew_addr = free_ff;  ew_data = cmd_ff.item_value;
      lw_en = 1'b0;  lw_addr = free_ff;  lw_data = head_ff;
      unique case (state_ff)
         clle_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cmd_in = q_cmd;
               st_in = clle_pkg::ST_OK;  rd_in = '0;  slot_in = '0;
               cur_in = head_ff;  step_in = '0;  scan_in = '0;
               state_in = clle_pkg::BK_DONE;
               unique case (q_cmd.opcode)
                  clle_pkg::OP_INSERT: begin
                     if (CW'(q_cmd.position) > len_ff || q_cmd.position > 9'(len_ff))
                        st_in = clle_pkg::ST_RANGE;
                     else state_in = clle_pkg::BK_FREE_SCAN;
                  end
                  clle_pkg::OP_DELETE, clle_pkg::OP_GET: begin
                     if (q_cmd.position >= 9'(len_ff)) st_in = clle_pkg::ST_RANGE;
                     else state_in = clle_pkg::BK_WALK_REQ;
                  end
                  clle_pkg::OP_SEARCH: begin
                     st_in = clle_pkg::ST_MISS;
                     state_in = clle_pkg::BK_SRCH_REQ;
                  end
                  clle_pkg::OP_CLEAR: state_in = clle_pkg::BK_CLEAR;
                  default: ;
               endcase
            end
         end
         clle_pkg::BK_FREE_SCAN: begin
            if (scan_ff == CW'(clle_pkg::ListSlots)) begin
               st_in = clle_pkg::ST_FULL;
               state_in = clle_pkg::BK_DONE;
            end else if (!used_ff[scan_ff[SW-1:0]]) begin
               free_in = scan_ff[SW-1:0];
               ew_en = 1'b1;  ew_addr = scan_ff[SW-1:0];
               used_in[scan_ff[SW-1:0]] = 1'b1;
               slot_in = scan_ff[SW-1:0];
               len_in = len_ff + CW'(1);
               if (cmd_ff.position == '0) begin
                  lw_en = 1'b1;  lw_addr = scan_ff[SW-1:0];  lw_data = head_ff;
                  head_in = scan_ff[SW-1:0];
                  state_in = clle_pkg::BK_DONE;
               end else state_in = clle_pkg::BK_WALK_REQ;
            end else scan_in = scan_ff + CW'(1);
         end
         clle_pkg::BK_WALK_REQ: begin
            if (cmd_ff.opcode == clle_pkg::OP_DELETE && cmd_ff.position == '0) begin
               rd_en = 1'b1;  rd_addr = head_ff;
               cur_in = head_ff;
               state_in = clle_pkg::BK_DEL_WAIT;
            end else if (step_ff == target) begin
               rd_en = 1'b1;  rd_addr = cur_ff;
               state_in = (cmd_ff.opcode == clle_pkg::OP_GET) ? clle_pkg::BK_VAL_WAIT
                                                              : clle_pkg::BK_DEL_WAIT;
            end else begin
               rd_en = 1'b1;  rd_addr = cur_ff;
               state_in = clle_pkg::BK_WALK_WAIT;
            end
         end
         clle_pkg::BK_WALK_WAIT: begin
            cur_in = link_q;
            step_in = step_ff + CW'(1);
            state_in = clle_pkg::BK_WALK_REQ;
         end
         clle_pkg::BK_VAL_WAIT: begin
            rd_in = elem_q;
            state_in = clle_pkg::BK_DONE;
         end
         clle_pkg::BK_DEL_WAIT: begin
            state_in = clle_pkg::BK_DONE;
            if (cmd_ff.opcode == clle_pkg::OP_INSERT) begin
               lw_en = 1'b1;  lw_addr = free_ff;  lw_data = link_q;
               free_in = cur_ff;
               state_in = clle_pkg::BK_SRCH_WAIT;
            end else if (cmd_ff.position == '0) begin
               used_in[head_ff] = 1'b0;
               len_in = len_ff - CW'(1);
               head_in = (len_ff == CW'(1)) ? '0 : link_q;
            end else if (scan_ff == '0) begin
               free_in = link_q;
               scan_in = CW'(1);
               rd_en = 1'b1;  rd_addr = link_q;
               state_in = clle_pkg::BK_DEL_WAIT;
            end else begin
               lw_en = 1'b1;  lw_addr = cur_ff;  lw_data = link_q;
               used_in[free_ff] = 1'b0;
               len_in = len_ff - CW'(1);
               if (len_ff == CW'(1)) head_in = '0;
            end
         end
         clle_pkg::BK_SRCH_WAIT: begin
            if (cmd_ff.opcode == clle_pkg::OP_INSERT) begin
               lw_en = 1'b1;  lw_addr = free_ff;  lw_data = slot_ff;
               state_in = clle_pkg::BK_DONE;
            end else if (elem_q == cmd_ff.item_value) begin
               st_in = clle_pkg::ST_OK;  slot_in = cur_ff;
               state_in = clle_pkg::BK_DONE;
            end else begin
               cur_in = link_q;
               step_in = step_ff + CW'(1);
               state_in = clle_pkg::BK_SRCH_REQ;
            end
         end
         clle_pkg::BK_SRCH_REQ: begin
            if (step_ff >= len_ff) state_in = clle_pkg::BK_DONE;
            else begin
               rd_en = 1'b1;  rd_addr = cur_ff;
               state_in = clle_pkg::BK_SRCH_WAIT;
            end
         end
         clle_pkg::BK_CLEAR: begin
            used_in = '0;  len_in = '0;  head_in = '0;
            state_in = clle_pkg::BK_DONE;
         end
         clle_pkg::BK_DONE: begin
            strobe_in = 1'b1;
            state_in = clle_pkg::BK_IDLE;
         end
         default: state_in = clle_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= clle_pkg::BK_IDLE;
         used_ff   <= '0;
         head_ff   <= '0;
         len_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         head_ff   <= head_in;
         len_ff    <= len_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;   cur_ff  <= cur_in;   step_ff <= step_in;
      free_ff <= free_in;  scan_ff <= scan_in;  st_ff   <= st_in;
      rd_ff   <= rd_in;    slot_ff <= slot_in;
   end

   assign idle              = (state_ff == clle_pkg::BK_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = st_ff;
   assign rsp_read_value    = rd_ff;
   assign rsp_slot_index    = slot_ff;
   assign rsp_element_count = 9'(len_ff);

   `ASSERT_IMPL(a_len_bound, clock, reset, 1'b1, len_ff <= CW'(clle_pkg::ListSlots),
                "list length exceeds slot count")
   `ASSERT_NEXT(a_strobe_idle, clock, reset, state_ff == clle_pkg::BK_DONE,
                strobe_ff && state_ff == clle_pkg::BK_IDLE, "result not issued")
   `ASSERT_IMPL(a_empty_head, clock, reset, strobe_ff && len_ff == '0, head_ff == '0,
                "empty list keeps a head")

endmodule

// ----- dv/list_engine_checker.sv -----
module list_engine_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [8:0]         req_position,
   input  logic signed [31:0] req_item_value,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_read_value,
   input  logic [7:0]         rsp_slot_index,
   input  logic [8:0]         rsp_element_count,
   output int                 fail_count,
   output int                 pending_count,
   output int                 list_size
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [7:0]  slot_index;
      logic [8:0]  element_count;
   } list_result_type;

   logic [31:0] values [clle_pkg::ListSlots];
   logic [7:0]  links  [clle_pkg::ListSlots];
   logic        used   [clle_pkg::ListSlots];
   logic [7:0]  head;
   int          length;
   list_result_type expected_results[$];

   function automatic logic [7:0] slot_at(input int pos);
      logic [7:0] s;
      s = head;
      for (int i = 0; i < pos; i++) s = links[s];
      return s;
   endfunction

   function automatic list_result_type apply_command(input logic [2:0] op,
         input logic [8:0] pos, input logic [31:0] val);
      list_result_type r;
      int free_slot;
      logic [7:0] prev, victim, s;
      r = '0;
      case (op)
         clle_pkg::OP_INSERT: begin
            if (pos > length) begin
               r.status = clle_pkg::ST_RANGE;
            end else begin
               free_slot = -1;
               for (int i = 0; i < clle_pkg::ListSlots; i++)
                  if (!used[i] && free_slot < 0) free_slot = i;
               if (free_slot < 0) begin
                  r.status = clle_pkg::ST_FULL;
               end else begin
                  values[free_slot] = val;
                  used[free_slot] = 1'b1;
                  if (pos == 0) begin
                     links[free_slot] = head;
                     head = free_slot[7:0];
                  end else begin
                     prev = slot_at(pos - 1);
                     links[free_slot] = links[prev];
                     links[prev] = free_slot[7:0];
                  end
                  length++;
                  r.slot_index = free_slot[7:0];
               end
            end
         end
         clle_pkg::OP_DELETE: begin
            if (pos >= length) begin
               r.status = clle_pkg::ST_RANGE;
            end else begin
               if (pos == 0) begin
                  victim = head;
                  head = links[victim];
               end else begin
                  prev = slot_at(pos - 1);
                  victim = links[prev];
                  links[prev] = links[victim];
               end
               used[victim] = 1'b0;
               length--;
               if (length == 0) head = '0;
            end
         end
         clle_pkg::OP_GET: begin
            if (pos >= length) r.status = clle_pkg::ST_RANGE;
            else r.read_value = values[slot_at(pos)];
         end
         clle_pkg::OP_SEARCH: begin
            r.status = clle_pkg::ST_MISS;
            s = head;
            for (int i = 0; i < length; i++) begin
               if (r.status == clle_pkg::ST_MISS && values[s] == val) begin
                  r.status = clle_pkg::ST_OK;
                  r.slot_index = s;
               end
               s = links[s];
            end
         end
         clle_pkg::OP_CLEAR: begin
            for (int i = 0; i < clle_pkg::ListSlots; i++) used[i] = 1'b0;
            length = 0;
            head = '0;
         end
         default: ;
      endcase
      r.element_count = length[8:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      length = 0;
      head = '0;
      for (int i = 0; i < clle_pkg::ListSlots; i++) used[i] = 1'b0;
   end

   assign list_size = length;

   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", {30'd0, rsp_status}, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_slot_index !== want.slot_index)
                  report_mismatch("slot_index", rsp_slot_index, want.slot_index);
               if (rsp_element_count !== want.element_count)
                  report_mismatch("element_count", rsp_element_count,
                                  want.element_count);
            end
         end
         if (start && !busy)
            expected_results.push_back(apply_command(req_opcode, req_position,
                                                     req_item_value));
      end
      pending_count = expected_results.size();
   end

endmodule

// ----- dv/tb_cursor_linked_list_engine_top.sv -----
module tb_cursor_linked_list_engine_top;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_opcode;
   logic [8:0]         req_position;
   logic signed [31:0] req_item_value;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic [7:0]         rsp_slot_index;
   logic [8:0]         rsp_element_count;
   int                 fail_count;
   int                 pending_count;
   int                 list_size;

   cursor_linked_list_engine_top dut (.*);

   list_engine_checker checker_inst (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic send_request(input logic [2:0] op, input logic [8:0] pos,
         input logic [31:0] val);
      start = 1'b1;
      req_opcode = op;
      req_position = pos;
      req_item_value = val;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [8:0] pick_position(input int span);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 9'($urandom_range(0, 511));
      if (r == 1) return 9'(span);
      if (r == 2) return 9'd0;
      return 9'($urandom_range(0, span));
   endfunction

   initial begin
      logic [2:0] op;
      int burst;
      int pick;
      logic [31:0] val;
      start = 1'b0;
      req_opcode = '0;
      req_position = '0;
      req_item_value = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(clle_pkg::OP_GET, 9'd0, 32'd0);
      send_request(clle_pkg::OP_DELETE, 9'd0, 32'd0);
      send_request(clle_pkg::OP_SEARCH, 9'd0, 32'h8000_0000);
      send_request(clle_pkg::OP_INSERT, 9'd1, 32'd5);
      send_request(clle_pkg::OP_INSERT, 9'd0, 32'h8000_0000);
      send_request(clle_pkg::OP_INSERT, 9'd1, 32'h7FFF_FFFF);
      send_request(clle_pkg::OP_INSERT, 9'd0, 32'hFFFF_FFFF);
      send_request(clle_pkg::OP_INSERT, 9'd3, 32'd0);
      send_request(clle_pkg::OP_GET, 9'd3, 32'd0);
      send_request(clle_pkg::OP_GET, 9'd4, 32'd0);
      send_request(clle_pkg::OP_GET, 9'd511, 32'd0);
      send_request(clle_pkg::OP_SEARCH, 9'd0, 32'h7FFF_FFFF);
      send_request(clle_pkg::OP_SEARCH, 9'd0, 32'd12345);
      send_request(clle_pkg::OP_DELETE, 9'd2, 32'd0);
      send_request(clle_pkg::OP_DELETE, 9'd0, 32'd0);
      send_request(3'd5, 9'd0, 32'd0);
      send_request(3'd7, 9'h1FF, 32'hFFFF_FFFF);
      send_request(clle_pkg::OP_CLEAR, 9'd0, 32'd0);
      for (int i = 0; i < 257; i++) begin
         send_request(clle_pkg::OP_INSERT, (i % 3 == 0) ? 9'd0 : 9'(list_size),
                      $urandom);
         idle_gap();
      end
      send_request(clle_pkg::OP_INSERT, 9'd256, 32'd1);
      send_request(clle_pkg::OP_GET, 9'd255, 32'd0);
      send_request(clle_pkg::OP_DELETE, 9'd255, 32'd0);
      send_request(clle_pkg::OP_DELETE, 9'd0, 32'd0);
      send_request(clle_pkg::OP_CLEAR, 9'd0, 32'd0);

      for (int n = 0; n < 780; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2, 3: op = clle_pkg::OP_INSERT;
               4, 5: op = clle_pkg::OP_DELETE;
               6: op = clle_pkg::OP_GET;
               7: op = clle_pkg::OP_SEARCH;
               8: op = ($urandom_range(0, 7) == 0) ? clle_pkg::OP_CLEAR
                                                   : 3'($urandom_range(5, 7));
               default: op = clle_pkg::OP_SEARCH;
            endcase
            val = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 15);
            send_request(op, pick_position(
                         list_size + (op == clle_pkg::OP_INSERT ? 0 : -1) < 0 ?
                         0 : list_size + (op == clle_pkg::OP_INSERT ? 0 : -1)), val);
            n++;
         end
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end

      while (pending_count != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS cursor_linked_list_engine_top");
      end else begin
         $display("FAIL cursor_linked_list_engine_top");
      end
      $finish;
   end

   initial begin
      #50000000;
      $display("FAIL cursor_linked_list_engine_top");
      $finish;
   end

endmodule
